@@ design/tfc_pkg.sv @@
package tfc_pkg;

   // result status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_FIRST    = 3'd1;
   localparam logic [2:0] ST_BAD_CK_LEN   = 3'd2;
   localparam logic [2:0] ST_BAD_REC_LEN  = 3'd3;
   localparam logic [2:0] ST_TOO_LONG     = 3'd4;
   localparam logic [2:0] ST_CK_MISMATCH  = 3'd5;

   // register indexes on the csr port (byte address = 4 * index)
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_END_TYPE      = 2'd0;
   localparam logic [1:0] REG_CHECKSUM_TYPE = 2'd1;
   localparam logic [1:0] REG_CHECKSUM_LEN  = 2'd2;
   localparam logic [1:0] REG_MAX_LEN       = 2'd3;

   // reset values of the registers
   localparam logic [7:0] END_TYPE_RST      = 8'd0;
   localparam logic [7:0] CHECKSUM_TYPE_RST = 8'd1;
   localparam logic [7:0] CHECKSUM_LEN_RST  = 8'd1;
   localparam logic [7:0] MAX_LEN_RST       = 8'd255;

   // bytes of a frame that are not record value: checksum type, length, end byte, ...
   localparam logic [8:0] REC_OVERHEAD = 9'd5;

   typedef struct packed {
      logic [7:0] end_type;
      logic [7:0] checksum_type;
      logic [7:0] checksum_len;
      logic [7:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] frame_length;
      logic [7:0] computed_checksum;
      logic [7:0] received_checksum;
   } result_type;

endpackage

@@ design/tfc_req_if.sv @@
interface tfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

@@ design/tfc_rsp_if.sv @@
interface tfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] frame_length;
   logic [7:0] computed_checksum;
   logic [7:0] received_checksum;

   modport source (output valid, output status, output frame_length,
                   output computed_checksum, output received_checksum, input ready);
   modport sink (input valid, input status, input frame_length,
                 input computed_checksum, input received_checksum, output ready);
endinterface

@@ design/tlv_frame_checker.sv @@
// TLV frame checker.
// req_bus carries one datagram byte per beat; frame_start marks the first
// byte of a frame. The first record must be the checksum record; the XOR of
// all later type, length and value bytes is compared with its first value
// byte when the end-type byte arrives. rsp_bus carries one result per frame,
// at the end byte or at the first error; later bytes of that frame are
// ignored until the next frame start, which also abandons an open frame.
// Throughput: one byte per cycle while the output buffer has space; each
// byte is checked by the parse stage in the cycle it is accepted, and its
// result goes into a two-entry output buffer whose head drives rsp_bus.
// When the receiver stalls, one result can wait while bytes keep
// flowing; req_bus.ready drops only while two results are held.
// The csr_ APB port holds end_type, checksum_type, checksum_len and max_len
// at byte addresses 0, 4, 8 and 12; write them only while no frame is open.
// Reset (synchronous) returns the registers to their defaults, clears the
// output buffer and leaves the parser waiting for a frame start.
module tlv_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   tfc_req_if.sink                         req_bus,
   tfc_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tfc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tfc_pkg::*;

   cfg_type    cfg_ff;
   logic       csr_write;
   logic [1:0] reg_index;
   logic       has_space;
   logic       beat_accept;
   logic       result_valid;
   result_type result;

   // configuration registers
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.end_type      <= END_TYPE_RST;
         cfg_ff.checksum_type <= CHECKSUM_TYPE_RST;
         cfg_ff.checksum_len  <= CHECKSUM_LEN_RST;
         cfg_ff.max_len       <= MAX_LEN_RST;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_END_TYPE:      cfg_ff.end_type      <= csr_pwdata[7:0];
            REG_CHECKSUM_TYPE: cfg_ff.checksum_type <= csr_pwdata[7:0];
            REG_CHECKSUM_LEN:  cfg_ff.checksum_len  <= csr_pwdata[7:0];
            REG_MAX_LEN:       cfg_ff.max_len       <= csr_pwdata[7:0];
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_index)
         REG_END_TYPE:      csr_prdata = {24'd0, cfg_ff.end_type};
         REG_CHECKSUM_TYPE: csr_prdata = {24'd0, cfg_ff.checksum_type};
         REG_CHECKSUM_LEN:  csr_prdata = {24'd0, cfg_ff.checksum_len};
         REG_MAX_LEN:       csr_prdata = {24'd0, cfg_ff.max_len};
      endcase
   end

   // take a byte whenever the output buffer can hold a result
   assign req_bus.ready = has_space;
   assign beat_accept   = req_bus.valid && has_space;

   tfc_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .data_byte    (req_bus.data_byte),
      .frame_start  (req_bus.frame_start),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   tfc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .has_space (has_space),
      .rsp_bus   (rsp_bus)
   );

   // a clean frame carries matching checksums
   a_ok_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == ST_OK) |->
         (rsp_bus.computed_checksum == rsp_bus.received_checksum))
      else $error("ok result with differing checksums");

   // a clean frame fits within max_len
   a_ok_fits : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == ST_OK) |->
         (rsp_bus.frame_length <= cfg_ff.max_len))
      else $error("ok result longer than max_len");

   // no result is shown right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");

endmodule

@@ design/tfc_parse.sv @@
module tfc_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_accept,
   input  logic [7:0]          data_byte,
   input  logic                frame_start,
   input  tfc_pkg::cfg_type    cfg,
   output logic                result_valid,
   output tfc_pkg::result_type result
);
   import tfc_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_TYPE  = 2'd1;
   localparam logic [1:0] PH_LEN   = 2'd2;
   localparam logic [1:0] PH_VALUE = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] ck_ff, ck_in;
   logic [8:0] total_ff, total_in;
   logic       first_rec_ff, first_rec_in;
   logic       first_val_ff, first_val_in;

   logic [1:0] ph;
   logic [8:0] tot_plus1;
   logic [8:0] tot_plus_len;
   logic [7:0] left_dec;
   logic       len_bad;
   logic       emit;
   logic [2:0] status;

   // next-state logic for one accepted byte
   always_comb begin
      phase_in     = phase_ff;
      left_in      = left_ff;
      xor_in       = xor_ff;
      ck_in        = ck_ff;
      total_in     = total_ff;
      first_rec_in = first_rec_ff;
      first_val_in = first_val_ff;
      emit         = 1'b0;
      status       = ST_OK;

      // a frame start wipes the frame state before the byte is looked at
      ph = frame_start ? PH_TYPE : phase_ff;
      if (frame_start) begin
         left_in      = '0;
         xor_in       = '0;
         ck_in        = '0;
         total_in     = '0;
         first_rec_in = 1'b1;
         first_val_in = 1'b1;
      end

      tot_plus1    = total_in + 9'd1;
      tot_plus_len = tot_plus1 + {1'b0, data_byte};
      len_bad      = (data_byte == 8'd0) ||
                     (({1'b0, data_byte} + REC_OVERHEAD) > {1'b0, cfg.max_len});
      left_dec     = (left_in != 8'd0) ? left_in - 8'd1 : 8'd0;

      if (beat_accept) begin
         unique case (ph)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_TYPE: begin
               total_in = tot_plus1;
               phase_in = PH_LEN;
               if (first_rec_in) begin
                  if (data_byte != cfg.checksum_type) begin
                     emit   = 1'b1;
                     status = ST_BAD_FIRST;
                  end
               end else if (data_byte == cfg.end_type) begin
                  emit = 1'b1;
                  if (tot_plus1 > {1'b0, cfg.max_len}) begin
                     status = ST_TOO_LONG;
                  end else if (xor_in != ck_in) begin
                     status = ST_CK_MISMATCH;
                  end else begin
                     status = ST_OK;
                  end
               end else begin
                  xor_in = xor_in ^ data_byte;
               end
            end
            PH_LEN: begin
               if (first_rec_in && (data_byte != cfg.checksum_len)) begin
                  total_in = tot_plus1;
                  emit     = 1'b1;
                  status   = ST_BAD_CK_LEN;
               end else if (len_bad) begin
                  total_in = tot_plus1;
                  emit     = 1'b1;
                  status   = ST_BAD_REC_LEN;
               end else begin
                  total_in = tot_plus_len;
                  if (tot_plus_len > {1'b0, cfg.max_len}) begin
                     emit   = 1'b1;
                     status = ST_TOO_LONG;
                  end else begin
                     if (!first_rec_in) begin
                        xor_in = xor_in ^ data_byte;
                     end
                     left_in  = data_byte;
                     phase_in = PH_VALUE;
                  end
               end
            end
            PH_VALUE: begin
               // only the first checksum byte is kept, the rest are dropped
               if (first_rec_in) begin
                  if (first_val_in) begin
                     ck_in        = data_byte;
                     first_val_in = 1'b0;
                  end
               end else begin
                  xor_in = xor_in ^ data_byte;
               end
               left_in  = left_dec;
               phase_in = PH_VALUE;
               if (left_dec == 8'd0) begin
                  first_rec_in = 1'b0;
                  phase_in     = PH_TYPE;
               end
            end
         endcase
         if (emit) begin
            phase_in = PH_IDLE;
         end
      end else begin
         left_in      = left_ff;
         xor_in       = xor_ff;
         ck_in        = ck_ff;
         total_in     = total_ff;
         first_rec_in = first_rec_ff;
         first_val_in = first_val_ff;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         left_ff      <= '0;
         xor_ff       <= '0;
         ck_ff        <= '0;
         total_ff     <= '0;
         first_rec_ff <= 1'b1;
         first_val_ff <= 1'b1;
      end else begin
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         xor_ff       <= xor_in;
         ck_ff        <= ck_in;
         total_ff     <= total_in;
         first_rec_ff <= first_rec_in;
         first_val_ff <= first_val_in;
      end
   end

   // result of this beat, length saturated to 8 bits
   assign result_valid             = emit;
   assign result.status            = status;
   assign result.frame_length      = total_in[8] ? 8'hFF : total_in[7:0];
   assign result.computed_checksum = xor_in;
   assign result.received_checksum = ck_in;

endmodule

@@ design/tfc_rsp_buf.sv @@
module tfc_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tfc_pkg::result_type push_data,
   output logic                has_space,
   tfc_rsp_if.source           rsp_bus
);
   import tfc_pkg::*;

   result_type slot0_ff, slot1_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_bus.valid && rsp_bus.ready;
   assign has_space = (count_ff != 2'd2);

   // occupancy: head in slot0, second entry in slot1
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // advance the head on pop, fill the first free slot on push
   always_ff @(posedge clock) begin
      if (pop) begin
         slot0_ff <= (count_ff == 2'd2) ? slot1_ff : push_data;
      end else if (push && (count_ff == 2'd0)) begin
         slot0_ff <= push_data;
      end
      if (push && !pop && (count_ff == 2'd1)) begin
         slot1_ff <= push_data;
      end
   end

   assign rsp_bus.valid             = (count_ff != 2'd0);
   assign rsp_bus.status            = slot0_ff.status;
   assign rsp_bus.frame_length      = slot0_ff.frame_length;
   assign rsp_bus.computed_checksum = slot0_ff.computed_checksum;
   assign rsp_bus.received_checksum = slot0_ff.received_checksum;

endmodule
